/* hdl/vqfn_pkg.sv */
// ----------------------------------------------------------------------------
// vqfn_pkg
// Shared types, constants and command/status structs for the vertex quantizer.
// ----------------------------------------------------------------------------
package vqfn_pkg;

    localparam int POS_W   = 25;
    localparam int SIZE_W  = 9;
    localparam int LIGHT_W = 17;
    localparam int UNORM_W = 16;
    localparam int TEX_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int DIFF_W  = 26;
    localparam int CROSS_W = 53;
    localparam int MAG_W   = 52;
    localparam int LEN_W   = 106;
    localparam int SLOT_W  = 3;
    localparam int FACE_VERTICES_DEF = 6;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // s_tdata: pos_x, pos_y, pos_z, tex_u, tex_v, light_red/green/blue
    localparam int S_DATA_W = 192;
    // m_tdata: unorm xyz, u, v, rgb bytes, normal xyz
    localparam int M_DATA_W = 160;

    typedef struct packed {
        logic [UNORM_W-1:0] ux;
        logic [UNORM_W-1:0] uy;
        logic [UNORM_W-1:0] uz;
        logic [TEX_W-1:0]   u;
        logic [TEX_W-1:0]   v;
        logic [BYTE_W-1:0]  r;
        logic [BYTE_W-1:0]  g;
        logic [BYTE_W-1:0]  b;
    } vrec_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture input vertex
        logic       qstart;    // start position divide
        logic       nstart;    // start normal computation
        logic       set_def;   // force default normal
        logic [1:0] osel;      // 0,1 held vertex, 2 current, 3 store held
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic qdone;
        logic ndone;
    } dp_sts_t;

    localparam logic [1:0] OSEL_H0   = 2'd0;
    localparam logic [1:0] OSEL_H1   = 2'd1;
    localparam logic [1:0] OSEL_CUR  = 2'd2;
    localparam logic [1:0] OSEL_HOLD = 2'd3;

endpackage

/* hdl/vqfn_datapath.sv */
// ----------------------------------------------------------------------------
// vqfn_datapath
// Per-axis restoring dividers, light scaling, held vertices and the face
// normal unit (cross product, length, per-component rounding search).
// ----------------------------------------------------------------------------
module vqfn_datapath
    import vqfn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    input  logic [S_DATA_W-1:0]  in_data,
    input  logic [SIZE_W-1:0]    size_x,
    input  logic [SIZE_W-1:0]    size_y,
    input  logic [SIZE_W-1:0]    size_z,
    input  logic                 hold_idx,
    output logic [M_DATA_W-1:0]  out_data
);
    // quantizer: q = floor((s*131070 + den) / (2*den)), den = size<<16
    localparam int NUM_W  = 43;
    localparam int QB_W   = 17;
    localparam int HALF_W = MAG_W / 2;
    localparam int ACC_W  = LEN_W + 17;

    logic signed [POS_W-1:0] raw_reg [3];
    logic [TEX_W-1:0]   u_reg, v_reg;
    logic [BYTE_W-1:0]  rb_reg, gb_reg, bb_reg;
    logic [NUM_W-1:0]   rem_reg [3];
    logic [QB_W-1:0]    quo_reg [3];
    logic [2:0]         qsat_reg, qzero_reg;
    logic [5:0]         qcnt_reg;
    logic               qbusy_reg;
    logic [SIZE_W-1:0]  qsize_reg [3];

    logic signed [POS_W-1:0] hraw_reg [2][3];
    vrec_t              hv_reg [2];
    logic [3*BYTE_W-1:0] nrm_reg;

    function automatic logic [BYTE_W-1:0] qlight(input logic [LIGHT_W-1:0] l);
        logic [26:0] p;
        if (l[16]) return 8'hFF;
        p = 27'(l) * 27'd510 + 27'd65536;
        return p[24:17];
    endfunction

    // 64516 = 2^16 - 2^10 + 2^2
    function automatic logic [ACC_W-1:0] times_64516(input logic [LEN_W-1:0] s);
        return ACC_W'({s, 16'd0}) - ACC_W'({s, 10'd0}) + ACC_W'({s, 2'd0});
    endfunction

    logic [SIZE_W-1:0] szs [3];
    assign szs[0] = size_x;
    assign szs[1] = size_y;
    assign szs[2] = size_z;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                raw_reg[i] <= in_data[i*POS_W +: POS_W];
            end
            u_reg  <= in_data[75 +: TEX_W];
            v_reg  <= in_data[107 +: TEX_W];
            rb_reg <= qlight(in_data[139 +: LIGHT_W]);
            gb_reg <= qlight(in_data[156 +: LIGHT_W]);
            bb_reg <= qlight(in_data[173 +: LIGHT_W]);
        end
    end

    // restoring divide, one quotient bit per cycle, three lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qbusy_reg <= 1'b0;
            qcnt_reg  <= '0;
        end else if (cmd.qstart) begin
            qbusy_reg <= 1'b1;
            qcnt_reg  <= 6'(QB_W);
            for (int i = 0; i < 3; i++) begin
                qsize_reg[i] <= szs[i];
                qzero_reg[i] <= (szs[i] == '0) || raw_reg[i][POS_W-1] || (raw_reg[i] == '0);
                qsat_reg[i]  <= ({1'b0, raw_reg[i][POS_W-2:0]} >= {szs[i], 16'd0});
                rem_reg[i]   <= NUM_W'(raw_reg[i][POS_W-2:0]) * NUM_W'(131070)
                                + NUM_W'({szs[i], 16'd0});
                quo_reg[i]   <= '0;
            end
        end else if (qbusy_reg) begin
            for (int i = 0; i < 3; i++) begin
                logic [NUM_W-1:0] d;
                d = NUM_W'({qsize_reg[i], 17'd0}) << (qcnt_reg - 6'd1);
                if (rem_reg[i] >= d) begin
                    rem_reg[i] <= rem_reg[i] - d;
                    quo_reg[i] <= quo_reg[i] | (QB_W'(1) << (qcnt_reg - 6'd1));
                end
            end
            qcnt_reg <= qcnt_reg - 6'd1;
            if (qcnt_reg == 6'd1) qbusy_reg <= 1'b0;
        end
    end
    assign sts.qdone = !qbusy_reg;

    logic [UNORM_W-1:0] unq [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (qzero_reg[i])     unq[i] = '0;
            else if (qsat_reg[i]) unq[i] = '1;
            else                  unq[i] = quo_reg[i][UNORM_W-1:0];
        end
    end

    vrec_t cur;
    assign cur = '{ux: unq[0], uy: unq[1], uz: unq[2], u: u_reg, v: v_reg,
                   r: rb_reg, g: gb_reg, b: bb_reg};

    // normal unit: sequenced by a one-hot phase state machine
    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_DIFF  = 7'b0000010,
        N_CROSS = 7'b0000100,
        N_SQ    = 7'b0001000,
        N_MUL   = 7'b0010000,
        N_ACC   = 7'b0100000,
        N_SRCH  = 7'b1000000
    } nph_t;
    nph_t nph_reg;
    logic signed [DIFF_W-1:0]  a_reg [3], b_reg [3];
    logic signed [CROSS_W-1:0] c_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic [MAG_W-1:0]          hh_reg, hl_reg, ll_reg;
    logic [LEN_W-1:0]          sq_reg [3];
    logic [LEN_W-1:0]          len_reg;
    logic [1:0]                ci_reg;
    logic [6:0]                k_reg;
    logic [1:0]                pi_reg;
    logic [BYTE_W-1:0]         comp_reg [3];
    logic [ACC_W-1:0]          rhs_reg, lhs_reg, step_reg;

    logic signed [2*DIFF_W-1:0] prod [6];
    always_comb begin
        prod[0] = (2*DIFF_W)'(a_reg[1]) * (2*DIFF_W)'(b_reg[2]);
        prod[1] = (2*DIFF_W)'(a_reg[2]) * (2*DIFF_W)'(b_reg[1]);
        prod[2] = (2*DIFF_W)'(a_reg[2]) * (2*DIFF_W)'(b_reg[0]);
        prod[3] = (2*DIFF_W)'(a_reg[0]) * (2*DIFF_W)'(b_reg[2]);
        prod[4] = (2*DIFF_W)'(a_reg[0]) * (2*DIFF_W)'(b_reg[1]);
        prod[5] = (2*DIFF_W)'(a_reg[1]) * (2*DIFF_W)'(b_reg[0]);
    end

    logic [HALF_W-1:0] mhi, mlo;
    assign mhi = mag_reg[ci_reg][MAG_W-1:HALF_W];
    assign mlo = mag_reg[ci_reg][HALF_W-1:0];

    logic [LEN_W-1:0] len_sum;
    assign len_sum = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nph_reg <= N_IDLE;
            nrm_reg <= '0;
        end else if (cmd.set_def) begin
            nrm_reg <= {8'd0, 8'd127, 8'd0};
        end else begin
            unique case (nph_reg)
                N_IDLE: if (cmd.nstart) nph_reg <= N_DIFF;
                N_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        a_reg[i] <= DIFF_W'(hraw_reg[1][i]) - DIFF_W'(hraw_reg[0][i]);
                        b_reg[i] <= DIFF_W'(raw_reg[i]) - DIFF_W'(hraw_reg[0][i]);
                    end
                    nph_reg <= N_CROSS;
                end
                N_CROSS: begin
                    c_reg[0] <= CROSS_W'(prod[0]) - CROSS_W'(prod[1]);
                    c_reg[1] <= CROSS_W'(prod[2]) - CROSS_W'(prod[3]);
                    c_reg[2] <= CROSS_W'(prod[4]) - CROSS_W'(prod[5]);
                    nph_reg <= N_SQ;
                    ci_reg  <= '0;
                end
                N_SQ: begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= c_reg[i][CROSS_W-1] ? MAG_W'(-c_reg[i])
                                                          : MAG_W'(c_reg[i]);
                    end
                    nph_reg <= N_MUL;
                end
                // square as three half-width partial products
                N_MUL: begin
                    hh_reg  <= MAG_W'(mhi) * MAG_W'(mhi);
                    hl_reg  <= MAG_W'(mhi) * MAG_W'(mlo);
                    ll_reg  <= MAG_W'(mlo) * MAG_W'(mlo);
                    nph_reg <= N_ACC;
                end
                N_ACC: begin
                    sq_reg[ci_reg] <= LEN_W'({hh_reg, {MAG_W{1'b0}}})
                                      + LEN_W'({hl_reg, {(HALF_W+1){1'b0}}})
                                      + LEN_W'(ll_reg);
                    ci_reg <= ci_reg + 2'd1;
                    if (ci_reg == 2'd2) begin
                        nph_reg <= N_SRCH;
                        pi_reg  <= 2'd3;
                    end else begin
                        nph_reg <= N_MUL;
                    end
                end
                // lhs tracks len*(2k+1)^2 by adding 8*(k+1)*len per step
                N_SRCH: begin
                    if (pi_reg == 2'd3) begin
                        len_reg  <= len_sum;
                        lhs_reg  <= ACC_W'(len_sum);
                        step_reg <= ACC_W'({len_sum, 3'd0});
                        pi_reg   <= '0;
                        k_reg    <= '0;
                        rhs_reg  <= times_64516(sq_reg[0]);
                    end else if (len_reg == '0) begin
                        nrm_reg <= {8'd0, 8'd127, 8'd0};
                        nph_reg <= N_IDLE;
                    end else if (k_reg != 7'd127 && lhs_reg <= rhs_reg) begin
                        k_reg    <= k_reg + 7'd1;
                        lhs_reg  <= lhs_reg + step_reg;
                        step_reg <= step_reg + ACC_W'({len_reg, 3'd0});
                    end else begin
                        comp_reg[pi_reg] <= c_reg[pi_reg][CROSS_W-1] ? -{1'b0, k_reg}
                                                                      : {1'b0, k_reg};
                        k_reg    <= '0;
                        lhs_reg  <= ACC_W'(len_reg);
                        step_reg <= ACC_W'({len_reg, 3'd0});
                        if (pi_reg == 2'd2) begin
                            nrm_reg <= {c_reg[2][CROSS_W-1] ? -{1'b0, k_reg} : {1'b0, k_reg},
                                        comp_reg[1], comp_reg[0]};
                            nph_reg <= N_IDLE;
                        end else begin
                            rhs_reg <= times_64516(sq_reg[pi_reg+2'd1]);
                        end
                        pi_reg <= pi_reg + 2'd1;
                    end
                end
                default: nph_reg <= N_IDLE;
            endcase
        end
    end
    assign sts.ndone = (nph_reg == N_IDLE);

    // store held vertex after quantize completes
    always_ff @(posedge aclk) begin
        if (cmd.osel == OSEL_HOLD) begin
            hv_reg[hold_idx]     <= cur;
            hraw_reg[hold_idx]   <= raw_reg;
        end
    end

    vrec_t sel;
    always_comb begin
        unique case (cmd.osel)
            OSEL_H0: sel = hv_reg[0];
            OSEL_H1: sel = hv_reg[1];
            default: sel = cur;
        endcase
    end
    assign out_data = {nrm_reg, sel.b, sel.g, sel.r, sel.v, sel.u, sel.uz, sel.uy, sel.ux};
endmodule

/* hdl/vqfn_ctrl.sv */
// ----------------------------------------------------------------------------
// vqfn_ctrl
// Controller: accepts a vertex, sequences quantize, face normal and result
// beats, and tracks the slot within the face.
// ----------------------------------------------------------------------------
module vqfn_ctrl
    import vqfn_pkg::*;
#(
    parameter int FACE_VERTICES = FACE_VERTICES_DEF
)(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_last,
    output logic    s_ready,
    output logic    m_valid,
    output logic    m_last,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd,
    output logic    hold_idx
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_QST   = 7'b0000010,
        S_QWAIT = 7'b0000100,
        S_NWAIT = 7'b0001000,
        S_OUT   = 7'b0010000,
        S_HOLD  = 7'b0100000,
        S_DONE  = 7'b1000000
    } st_t;

    st_t st_reg, st_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [1:0] osel_reg, osel_next;
    logic last_reg, last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            slot_reg <= '0;
            osel_reg <= OSEL_CUR;
            last_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            slot_reg <= slot_next;
            osel_reg <= osel_next;
            last_reg <= last_next;
        end
    end

    assign s_ready  = st_reg == S_IDLE;
    assign m_valid  = st_reg == S_OUT;
    assign m_last   = last_reg && osel_reg == OSEL_CUR;
    assign hold_idx = slot_reg[0];

    always_comb begin
        st_next   = st_reg;
        slot_next = slot_reg;
        osel_next = osel_reg;
        last_next = last_reg;
        cmd       = '{load: 1'b0, qstart: 1'b0, nstart: 1'b0, set_def: 1'b0, osel: osel_reg};
        unique case (st_reg)
            S_IDLE: if (s_valid) begin
                cmd.load  = 1'b1;
                last_next = s_last;
                st_next   = S_QST;
            end
            S_QST: begin
                cmd.qstart = 1'b1;
                st_next    = S_QWAIT;
            end
            S_QWAIT: if (sts.qdone) begin
                if (slot_reg < SLOT_W'(2)) begin
                    if (last_reg) begin
                        cmd.set_def = 1'b1;
                        osel_next   = (slot_reg == '0) ? OSEL_CUR : OSEL_H0;
                        st_next     = S_OUT;
                    end else begin
                        st_next = S_HOLD;
                    end
                end else if (slot_reg == SLOT_W'(2)) begin
                    cmd.nstart = 1'b1;
                    osel_next  = OSEL_H0;
                    st_next    = S_NWAIT;
                end else begin
                    osel_next = OSEL_CUR;
                    st_next   = S_OUT;
                end
            end
            S_HOLD: begin
                cmd.osel  = OSEL_HOLD;
                slot_next = slot_reg + SLOT_W'(1);
                st_next   = S_IDLE;
            end
            S_NWAIT: if (sts.ndone) st_next = S_OUT;
            S_OUT: if (m_ready) begin
                if (osel_reg == OSEL_CUR) st_next = S_DONE;
                else if (osel_reg == OSEL_H0 && slot_reg != SLOT_W'(1)) osel_next = OSEL_H1;
                else osel_next = OSEL_CUR;
            end
            S_DONE: begin
                if (last_reg || slot_reg >= SLOT_W'(FACE_VERTICES - 1) ||
                    slot_reg < SLOT_W'(2))
                    slot_next = '0;
                else
                    slot_next = slot_reg + SLOT_W'(1);
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end
endmodule

/* hdl/vertex_quantize_face_normal_top.sv */
// ----------------------------------------------------------------------------
// vertex_quantize_face_normal_top
// Vertex quantizer with per-face normals.
// ----------------------------------------------------------------------------
// Vertices enter on the s_ beat channel, results leave on m_ with tlast set on
// the result for the mesh's final vertex. Register writes use the cfg_ channel
// (index 0..2 = size x/y/z) and are taken at any time, meant while idle.
// One vertex at a time: capture, a bit-serial divide per axis (three lanes
// in parallel), then either a hold or one result beat per held vertex plus the
// current. A held vertex frees the input once it is stored, one that leaves at
// once after its result beats are taken. On the third vertex of a face the
// normal unit runs first: differences, cross product, magnitudes, three
// squares (multiply and accumulate each) and a rounding search per component.
// A stalled receiver holds the result beat and the input stays not ready.
// Reset clears the face slot and normal and sets the sizes to (16, 256, 16).
// ----------------------------------------------------------------------------
module vertex_quantize_face_normal_top
    import vqfn_pkg::*;
#(
    parameter int FACE_VERTICES = FACE_VERTICES_DEF
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, light_red, light_green, light_blue
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // unorm_x, unorm_y, unorm_z, out_u, out_v, red, green, blue, normal x/y/z
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);
    logic [SIZE_W-1:0] sx_reg, sy_reg, sz_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    hold_idx;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg <= 9'd16;
            sy_reg <= 9'd256;
            sz_reg <= 9'd16;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SIZE_X: sx_reg <= cfg_data;
                REG_SIZE_Y: sy_reg <= cfg_data;
                REG_SIZE_Z: sz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    vqfn_ctrl #(.FACE_VERTICES(FACE_VERTICES)) u_ctrl (
        .aclk, .aresetn, .s_valid(s_tvalid), .s_last(s_tlast), .s_ready(s_tready),
        .m_valid(m_tvalid), .m_last(m_tlast), .m_ready(m_tready),
        .sts, .cmd, .hold_idx
    );

    vqfn_datapath u_dp (
        .aclk, .aresetn, .cmd, .sts, .in_data(s_tdata),
        .size_x(sx_reg), .size_y(sy_reg), .size_z(sz_reg),
        .hold_idx, .out_data(m_tdata)
    );

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the vertex quantizer: position and light quantization, face normals,
// short faces and size register settings, against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb;
    import vqfn_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;

    typedef struct {
        logic [M_DATA_W-1:0] data;
        logic                last;
    } vout_t;

    typedef struct {
        longint raw [3];
        vout_t  vtx;
    } held_t;

    vout_t       expected_verts [$];
    held_t       held [2];
    int          slot_q;
    logic [23:0] cur_normal;
    int          sz [3];
    int          errors;
    int          results_seen;
    int          verts_sent;
    int          hold_cycles;
    bit          rx_random;

    vertex_quantize_face_normal_top dut (.*);

    initial forever #6 aclk = ~aclk;

    initial begin
        #60000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int short_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [15:0] quant_axis(longint p, int size);
        longint den;
        if (size == 0 || p <= 0) return 16'd0;
        den = longint'(size) << 16;
        if (p >= den) return 16'hffff;
        return 16'((p * 131070 + den) / (2 * den));
    endfunction

    function automatic logic [7:0] quant_chan(logic [16:0] l);
        if (l >= 17'd65536) return 8'd255;
        return 8'((longint'(l) * 510 + 65536) >> 17);
    endfunction

    function automatic logic [7:0] snorm_byte(longint c, logic [127:0] len2);
        logic [127:0] mag;
        logic [127:0] rhs;
        int r;
        mag = c < 0 ? 128'(-c) : 128'(c);
        rhs = mag * mag * 128'd64516;
        r = 0;
        for (int k = 0; k < 127; k++) begin
            if (len2 * 128'((2 * k + 1) * (2 * k + 1)) <= rhs) r = k + 1;
            else break;
        end
        if (c < 0) r = -r;
        return 8'(r);
    endfunction

    function automatic logic [23:0] face_normal_of(longint p0 [3], longint p1 [3],
                                                   longint p2 [3]);
        longint a [3];
        longint b [3];
        longint c [3];
        logic [127:0] len2;
        for (int i = 0; i < 3; i++) begin
            a[i] = p1[i] - p0[i];
            b[i] = p2[i] - p0[i];
        end
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) return {8'd0, 8'd127, 8'd0};
        len2 = '0;
        for (int i = 0; i < 3; i++) begin
            logic [127:0] m;
            m = c[i] < 0 ? 128'(-c[i]) : 128'(c[i]);
            len2 += m * m;
        end
        return {snorm_byte(c[2], len2), snorm_byte(c[1], len2), snorm_byte(c[0], len2)};
    endfunction

    function automatic vout_t with_normal(vout_t v, logic [23:0] n, logic last);
        vout_t r;
        r = v;
        r.data[159:136] = n;
        r.last = last;
        return r;
    endfunction

    task automatic predict_vertex(logic [S_DATA_W-1:0] d, logic last);
        longint raw [3];
        vout_t cur;
        for (int i = 0; i < 3; i++) raw[i] = longint'(signed'(d[i*25 +: 25]));
        cur.data = '0;
        for (int i = 0; i < 3; i++) cur.data[i*16 +: 16] = quant_axis(raw[i], sz[i]);
        cur.data[48 +: 64] = d[75 +: 64];
        for (int i = 0; i < 3; i++) cur.data[112 + i*8 +: 8] = quant_chan(d[139 + i*17 +: 17]);
        cur.last = 1'b0;
        if (slot_q < 2) begin
            if (last) begin
                cur_normal = {8'd0, 8'd127, 8'd0};
                for (int i = 0; i < slot_q; i++)
                    expected_verts.push_back(with_normal(held[i].vtx, cur_normal, 1'b0));
                expected_verts.push_back(with_normal(cur, cur_normal, 1'b1));
                slot_q = 0;
            end else begin
                held[slot_q].raw = raw;
                held[slot_q].vtx = cur;
                slot_q++;
            end
            return;
        end
        if (slot_q == 2) begin
            cur_normal = face_normal_of(held[0].raw, held[1].raw, raw);
            expected_verts.push_back(with_normal(held[0].vtx, cur_normal, 1'b0));
            expected_verts.push_back(with_normal(held[1].vtx, cur_normal, 1'b0));
        end
        expected_verts.push_back(with_normal(cur, cur_normal, last));
        slot_q = (last || slot_q + 1 >= FACE_VERTICES_DEF) ? 0 : slot_q + 1;
    endtask

    task automatic report(string what, logic [M_DATA_W:0] got, logic [M_DATA_W:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_verts.size() == 0) begin
                report("unexpected beat", {m_tlast, m_tdata}, '0);
            end else begin
                vout_t e;
                e = expected_verts.pop_front();
                if (m_tdata[47:0] !== e.data[47:0])
                    report("unorm", m_tdata[47:0], e.data[47:0]);
                if (m_tdata[111:48] !== e.data[111:48])
                    report("texture", m_tdata[111:48], e.data[111:48]);
                if (m_tdata[135:112] !== e.data[135:112])
                    report("light", m_tdata[135:112], e.data[135:112]);
                if (m_tdata[159:136] !== e.data[159:136])
                    report("normal", m_tdata[159:136], e.data[159:136]);
                if (m_tlast !== e.last) report("tlast", m_tlast, e.last);
            end
        end
    end

    // receiver: random stalls, always ready when rx_random is off, or a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (!rx_random) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic wait_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    // valid stays high after a beat until a gap or a drain drops it
    task automatic send_vertex(logic [S_DATA_W-1:0] d, logic last, bit gaps = 1);
        int gap;
        gap = gaps ? short_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            wait_cycles(gap);
        end
        s_tdata  <= d;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_vertex(d, last);
        verts_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_verts.size() != 0) @(posedge aclk);
        wait_cycles(500);
    endtask

    task automatic write_size(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_index <= idx;
        cfg_data  <= SIZE_W'(val);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_SIZE_X: sz[0] = val;
            REG_SIZE_Y: sz[1] = val;
            default:    sz[2] = val;
        endcase
    endtask

    task automatic set_sizes(int x, int y, int z);
        drain();
        write_size(REG_SIZE_X, x);
        write_size(REG_SIZE_Y, y);
        write_size(REG_SIZE_Z, z);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [S_DATA_W-1:0] pack_vertex(int px, int py, int pz,
                                                       logic [31:0] u, logic [31:0] v,
                                                       int r, int g, int b);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[0 +: 25]   = 25'(px);
        d[25 +: 25]  = 25'(py);
        d[50 +: 25]  = 25'(pz);
        d[75 +: 32]  = u;
        d[107 +: 32] = v;
        d[139 +: 17] = 17'(r);
        d[156 +: 17] = 17'(g);
        d[173 +: 17] = 17'(b);
        return d;
    endfunction

    function automatic int rand_pos(int size);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 33554431) - 16777216;
            1:       return -$urandom_range(0, 1000);
            default: return $urandom_range(0, (size + 1) << 16);
        endcase
    endfunction

    function automatic int rand_light();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(65536, 131071);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [S_DATA_W-1:0] rand_vertex();
        return pack_vertex(rand_pos(sz[0]), rand_pos(sz[1]), rand_pos(sz[2]),
                           $urandom, $urandom, rand_light(), rand_light(), rand_light());
    endfunction

    task automatic test_directed();
        // extremes of positions and lights, one full face
        send_vertex(pack_vertex(-16777216, 0, 16777215, 32'h0, 32'hffffffff, 0, 65536, 131071), 0);
        send_vertex(pack_vertex(16777215, -16777216, 0, 32'hffffffff, 32'h0, 131071, 0, 65535), 0);
        send_vertex(pack_vertex(65536, 16777215, -16777216, 32'h5a5a5a5a, 32'ha5a5a5a5,
                                32768, 128, 257), 0);
        send_vertex(pack_vertex(1, 1, 1, 32'h1, 32'h2, 1, 2, 3), 0);
        send_vertex(pack_vertex(524288, 32768, 1048575, 32'h3, 32'h4, 65535, 65536, 0), 0);
        send_vertex(pack_vertex(0, 0, 0, 32'h5, 32'h6, 0, 0, 0), 0);
        // degenerate face: six equal points
        for (int i = 0; i < 6; i++)
            send_vertex(pack_vertex(100, 200, 300, i, i, 1000, 2000, 3000), 0);
        // face cut short on its first, second and third vertex
        send_vertex(pack_vertex(65536, 65536, 65536, 7, 7, 7, 7, 7), 1);
        send_vertex(pack_vertex(0, 0, 0, 8, 8, 8, 8, 8), 0);
        send_vertex(pack_vertex(65536, 0, 0, 9, 9, 9, 9, 9), 1);
        send_vertex(pack_vertex(0, 0, 0, 1, 1, 1, 1, 1), 0);
        send_vertex(pack_vertex(65536, 0, 0, 2, 2, 2, 2, 2), 0);
        send_vertex(pack_vertex(0, 65536, 0, 3, 3, 3, 3, 3), 1);
        // axis-aligned face, then one with all axes large
        send_vertex(pack_vertex(0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_vertex(pack_vertex(0, 0, 65536, 0, 0, 0, 0, 0), 0);
        send_vertex(pack_vertex(65536, 0, 0, 0, 0, 0, 0, 0), 1);
        send_vertex(pack_vertex(-16777216, -16777216, -16777216, 0, 0, 0, 0, 0), 0);
        send_vertex(pack_vertex(16777215, -16777216, 16777215, 0, 0, 0, 0, 0), 0);
        send_vertex(pack_vertex(-16777216, 16777215, 16777215, 0, 0, 0, 0, 0), 1);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_vertex(rand_vertex(), $urandom_range(0, 19) == 0);
    endtask

    task automatic test_backpressure();
        hold_cycles = 3000;
        for (int i = 0; i < 12; i++) send_vertex(rand_vertex(), 1'b0, 0);
        send_vertex(rand_vertex(), 1'b1, 0);
    endtask

    task automatic test_pause();
        drain();
        for (int i = 0; i < 7; i++) send_vertex(rand_vertex(), i == 6);
    endtask

    initial begin
        errors = 0;
        results_seen = 0;
        verts_sent = 0;
        hold_cycles = 0;
        rx_random = 1;
        slot_q = 0;
        cur_normal = '0;
        sz[0] = 16;
        sz[1] = 256;
        sz[2] = 16;
        wait_cycles(10);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(60);
        test_backpressure();
        test_pause();
        set_sizes(0, 0, 0);
        test_directed();
        test_random(20);
        set_sizes(256, 1, 256);
        test_random(50);
        set_sizes(1, 0, 256);
        rx_random = 0;
        test_random(30);
        rx_random = 1;
        set_sizes($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 255));
        test_random(40);
        drain();
        $display("sent %0d vertices, checked %0d result beats", verts_sent, results_seen);
        $display("covered five size settings, short faces and long receiver stalls");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
